FILE: hdl/crc8fbc_pkg.sv
`timescale 1ns / 1ps

package crc8fbc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic REG_CRC_ENABLE     = 1'b0;
  localparam logic REG_DEVICE_ADDRESS = 1'b1;

  localparam int unsigned CFG_DATA_W = 7;

  // one byte through the MSB-first CRC-8, no reflection
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] c;
    c = crc ^ din;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/crc8fbc_if.sv
`timescale 1ns / 1ps

interface crc8fbc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       start_req;
  logic [7:0] reg_addr;
  logic [7:0] data_byte;
  logic [7:0] crc_byte;
  logic       last_in;

  modport source (output valid, mode, start_req, reg_addr, data_byte, crc_byte,
                  last_in, input ready);
  modport sink (input valid, mode, start_req, reg_addr, data_byte, crc_byte,
                last_in, output ready);
endinterface

interface crc8fbc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_data;
  logic [7:0]  out_crc;
  logic        crc_ok;
  logic        transfer_failed;
  logic [15:0] word_value;
  logic        word_ready;
  logic        last_out;

  modport source (output valid, out_data, out_crc, crc_ok, transfer_failed, word_value,
                  word_ready, last_out, input ready);
  modport sink (input valid, out_data, out_crc, crc_ok, transfer_failed, word_value,
                word_ready, last_out, output ready);
endinterface

FILE: hdl/crc8fbc_crc.sv
`timescale 1ns / 1ps

module crc8fbc_crc
  import crc8fbc_pkg::*;
(
  input  logic       mode,
  input  logic       start_req,
  input  logic [6:0] device_address,
  input  logic [7:0] reg_addr,
  input  logic [7:0] data_byte,
  output logic [7:0] crc
);

  logic [7:0] waddr;
  logic [7:0] raddr;
  logic [7:0] c_hdr;
  logic [7:0] c_frame;

  assign waddr = {device_address, 1'b0};
  assign raddr = {device_address, 1'b1};

  // bus framing prefix for the first byte of a transfer
  always_comb begin
    c_hdr = crc8_feed(crc8_feed(CRC_INIT, waddr), reg_addr);
    if (!start_req) begin
      c_frame = CRC_INIT;
    end else if (mode == MODE_READ) begin
      c_frame = crc8_feed(c_hdr, raddr);
    end else begin
      c_frame = c_hdr;
    end
  end

  assign crc = crc8_feed(c_frame, data_byte);

endmodule

FILE: hdl/crc8_framed_bus_transfer_checker_top.sv
`timescale 1ns / 1ps

// channel   | dir | handshake     | payload
// in_ch     | in  | valid / ready | mode, start_req, reg_addr, data_byte, crc_byte, last_in
// out_ch    | out | valid / ready | out_data, out_crc, crc_ok, transfer_failed, word_value,
//           |     |               | word_ready, last_out
// cfg       | in  | cfg_we        | cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; two registers (input register, result register).
// CRC framing and word pairing are settled combinationally between the two registers.
// Synchronous rst clears valid flags, pairing phase, failure flag and crc enable; device address resets to 8.
// A stalled result holds the result register; the input register still takes one request.

module crc8_framed_bus_transfer_checker_top
  import crc8fbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  crc8fbc_in_if.sink            in_ch,
  crc8fbc_out_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic       crc_enable;
  logic [6:0] device_address;

  logic       s1_valid;
  logic       s1_mode;
  logic       s1_start;
  logic [7:0] s1_reg;
  logic [7:0] s1_data;
  logic [7:0] s1_rx_crc;
  logic       s1_last;

  logic [7:0] held_low_byte;
  logic       odd_byte_phase;
  logic       failed_flag;

  logic       s1_adv;
  logic [7:0] crc_now;
  logic       phase_eff;
  logic       mismatch;
  logic       failed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_enable     <= 1'b0;
      device_address <= 7'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRC_ENABLE:     crc_enable     <= cfg_data[0];
        REG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign s1_adv      = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_mode   <= in_ch.mode;
      s1_start  <= in_ch.start_req;
      s1_reg    <= in_ch.reg_addr;
      s1_data   <= in_ch.data_byte;
      s1_rx_crc <= in_ch.crc_byte;
      s1_last   <= in_ch.last_in;
    end
  end

  crc8fbc_crc u_crc (
    .mode           (s1_mode),
    .start_req      (s1_start),
    .device_address (device_address),
    .reg_addr       (s1_reg),
    .data_byte      (s1_data),
    .crc            (crc_now)
  );

  assign phase_eff   = odd_byte_phase && !s1_start;
  assign mismatch    = crc_enable && (s1_mode == MODE_READ) && (crc_now != s1_rx_crc);
  assign failed_next = (failed_flag && !s1_start) || mismatch;

  always_ff @(posedge clk) begin
    if (rst) begin
      odd_byte_phase <= 1'b0;
      failed_flag    <= 1'b0;
      held_low_byte  <= 8'h00;
    end else if (s1_adv) begin
      odd_byte_phase <= !phase_eff && !s1_last;
      failed_flag    <= failed_next;
      if (!phase_eff) begin
        held_low_byte <= s1_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (s1_adv) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch.out_data        <= s1_data;
      out_ch.out_crc         <= crc_enable ? crc_now : 8'h00;
      out_ch.crc_ok          <= !mismatch;
      out_ch.transfer_failed <= failed_next;
      out_ch.word_value      <= phase_eff ? {s1_data, held_low_byte} : 16'h0000;
      out_ch.word_ready      <= phase_eff;
      out_ch.last_out        <= s1_last;
    end
  end

endmodule

FILE: hdl/crc8fbc_checker.sv
`timescale 1ns / 1ps

module crc8fbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data,
  input logic       crc_ok,
  input logic       transfer_failed
);

  // a request taken reaches the output once it has passed the input register, or is queued behind a held result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ##1 out_valid)
    else $error("accepted request did not reach the output");

  // input backs up only when both stages are full and the output is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled with room in the pipeline");

  // a mismatch always leaves the sticky flag set
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !crc_ok) |-> transfer_failed)
    else $error("crc mismatch without failure flag");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind crc8_framed_bus_transfer_checker_top crc8fbc_checker u_crc8fbc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_data        (out_ch.out_data),
  .crc_ok          (out_ch.crc_ok),
  .transfer_failed (out_ch.transfer_failed)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import crc8fbc_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic       mode;
    logic       start;
    logic [7:0] regaddr;
    logic [7:0] data;
    logic [7:0] rx_crc;
    logic       last;
  } req_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  crc;
    logic        ok;
    logic        failed;
    logic [15:0] word;
    logic        word_rdy;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       has;
    res_t       val;
  } pin_t;

  typedef struct packed {
    logic       en;
    logic [6:0] addr;
    req_t       req;
    logic       fix;
    pin_t       pin;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crc8fbc_in_if  in_ch();
  crc8fbc_out_if out_ch();

  crc8_framed_bus_transfer_checker_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state and its copy of the registers
  logic [7:0] held_lo;
  logic       odd_phase;
  logic       sticky_fail;
  logic       mon_en;
  logic [6:0] mon_addr;

  res_t owed_results[$];
  pin_t typed_results[$];
  row_t plan[$];
  int   err_count = 0;
  int   cycles = 0;

  logic       cur_en = 1'b0;
  logic [6:0] cur_addr = 7'd8;

  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_crc(input req_t q, input logic [6:0] addr);
    logic [7:0] wa;
    logic [7:0] c;
    wa = {addr, 1'b0};
    c = CRC_INIT;
    if (q.start) begin
      c = crc8_byte(c, wa);
      c = crc8_byte(c, q.regaddr);
      if (q.mode == MODE_READ) c = crc8_byte(c, wa | 8'h01);
    end
    return crc8_byte(c, q.data);
  endfunction

  function automatic res_t frame_result(input req_t q);
    res_t       r;
    logic [7:0] c;
    r = '0;
    r.ok = 1'b1;
    if (q.start) begin
      sticky_fail = 1'b0;
      odd_phase = 1'b0;
    end
    c = frame_crc(q, mon_addr);
    if (!mon_en) begin
      c = 8'h00;
    end else if (q.mode == MODE_READ && c != q.rx_crc) begin
      r.ok = 1'b0;
      sticky_fail = 1'b1;
    end
    if (odd_phase) begin
      r.word = {q.data, held_lo};
      r.word_rdy = 1'b1;
      odd_phase = 1'b0;
    end else begin
      held_lo = q.data;
      odd_phase = 1'b1;
    end
    if (q.last) odd_phase = 1'b0;
    r.data = q.data;
    r.crc = c;
    r.failed = sticky_fail;
    r.last = q.last;
    return r;
  endfunction

  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin : scoreboard
    req_t q;
    res_t want;
    res_t got;
    pin_t p;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst) begin
      owed_results.delete();
      held_lo = 8'h00;
      odd_phase = 1'b0;
      sticky_fail = 1'b0;
      mon_en = 1'b0;
      mon_addr = 7'd8;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CRC_ENABLE:     mon_en = cfg_data[0];
          REG_DEVICE_ADDRESS: mon_addr = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        q = '{in_ch.mode, in_ch.start_req, in_ch.reg_addr, in_ch.data_byte,
              in_ch.crc_byte, in_ch.last_in};
        want = frame_result(q);
        if (typed_results.size() != 0) begin
          p = typed_results.pop_front();
          if (p.has) want = p.val;
        end
        owed_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_data, out_ch.out_crc, out_ch.crc_ok, out_ch.transfer_failed,
                out_ch.word_value, out_ch.word_ready, out_ch.last_out};
        if (owed_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result with no request pending: data=%h crc=%h", $time,
                     got.data, got.crc);
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display({"%0t: expected data=%h crc=%h ok=%b fail=%b word=%h wrdy=%b last=%b",
                        " | actual data=%h crc=%h ok=%b fail=%b word=%h wrdy=%b last=%b"},
                       $time, want.data, want.crc, want.ok, want.failed, want.word,
                       want.word_rdy, want.last, got.data, got.crc, got.ok, got.failed,
                       got.word, got.word_rdy, got.last);
          end
        end
      end
    end
  end

  initial begin : receiver
    int   taken;
    int   hold;
    int   calm_left;
    bit   squeezed;
    bit   calm;
    logic rdy;
    taken = 0;
    hold = 0;
    calm_left = 0;
    squeezed = 1'b0;
    calm = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(40, 300);
      end else begin
        calm_left--;
      end
      if (rst) begin
        rdy = 1'b0;
      end else if (hold > 0) begin
        hold--;
        rdy = 1'b0;
      end else if (!squeezed && taken >= 60) begin
        // long back-pressure so the input side fills and stalls
        squeezed = 1'b1;
        hold = 199;
        rdy = 1'b0;
      end else begin
        hold = idle_len(calm);
        rdy = (hold == 0);
        if (hold > 0) hold--;
      end
      out_ch.ready <= rdy;
    end
  end

  task automatic offer(input req_t q, input pin_t p, input bit calm);
    int gap;
    gap = idle_len(calm);
    typed_results.push_back(p);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= q.mode;
    in_ch.start_req      <= q.start;
    in_ch.reg_addr       <= q.regaddr;
    in_ch.data_byte      <= q.data;
    in_ch.crc_byte       <= q.rx_crc;
    in_ch.last_in        <= q.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (owed_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic apply_cfg(input logic en, input logic [6:0] addr);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CRC_ENABLE;
    cfg_data  <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_index <= REG_DEVICE_ADDRESS;
    cfg_data  <= CFG_DATA_W'(addr);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_en = en;
    cur_addr = addr;
  endtask

  task automatic add_row(input logic en, input logic [6:0] addr, input req_t q,
                         input logic fix, input logic has, input res_t exp);
    row_t r;
    r.en = en;
    r.addr = addr;
    r.req = q;
    r.fix = fix;
    r.pin.has = has;
    r.pin.val = exp;
    plan.push_back(r);
  endtask

  initial begin : driver
    req_t       q;
    pin_t       none;
    logic       xfer_mode;
    logic [7:0] xfer_reg;
    logic       en;
    logic [6:0] addr;
    bit         calm;
    bit         trunc;
    int         sent;
    int         len;

    none = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_CRC_ENABLE;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_READ;
    in_ch.start_req <= 1'b0;
    in_ch.reg_addr <= 8'h00;
    in_ch.data_byte <= 8'h00;
    in_ch.crc_byte <= 8'h00;
    in_ch.last_in <= 1'b0;

    // crc off after reset: bytes pass through and pair
    add_row(1'b0, 7'd8, '{MODE_READ, 1'b1, 8'h00, 8'h34, 8'h00, 1'b0}, 1'b0, 1'b1,
            '{8'h34, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0});
    add_row(1'b0, 7'd8, '{MODE_READ, 1'b0, 8'h00, 8'h12, 8'hFF, 1'b0}, 1'b0, 1'b1,
            '{8'h12, 8'h00, 1'b1, 1'b0, 16'h1234, 1'b1, 1'b0});
    add_row(1'b0, 7'd8, '{MODE_WRITE, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b1}, 1'b0, 1'b1,
            '{8'hFF, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1});
    add_row(1'b0, 7'd8, '{MODE_WRITE, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 1'b1,
            '{8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0});
    add_row(1'b0, 7'd8, '{MODE_WRITE, 1'b1, 8'hFF, 8'hAB, 8'h00, 1'b1}, 1'b0, 1'b1,
            '{8'hAB, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1});
    // crc on, address 0; bytes without start are data-only
    add_row(1'b1, 7'd0, '{MODE_READ, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 1'b1,
            '{8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0});
    add_row(1'b1, 7'd0, '{MODE_READ, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b0}, 1'b0, 1'b1,
            '{8'hFF, 8'hF3, 1'b0, 1'b1, 16'hFF00, 1'b1, 1'b0});
    add_row(1'b1, 7'd0, '{MODE_READ, 1'b0, 8'h00, 8'h01, 8'h07, 1'b1}, 1'b0, 1'b1,
            '{8'h01, 8'h07, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1});
    add_row(1'b1, 7'd0, '{MODE_READ, 1'b1, 8'hFF, 8'h5A, 8'h00, 1'b0}, 1'b1, 1'b0, '0);
    add_row(1'b1, 7'd0, '{MODE_READ, 1'b0, 8'h00, 8'hC3, 8'h00, 1'b1}, 1'b1, 1'b0, '0);
    add_row(1'b1, 7'd0, '{MODE_WRITE, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 1'b1,
            '{8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0});
    add_row(1'b1, 7'd0, '{MODE_WRITE, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b1}, 1'b0, 1'b1,
            '{8'hFF, 8'hF3, 1'b1, 1'b0, 16'hFF00, 1'b1, 1'b1});
    add_row(1'b1, 7'd0, '{MODE_READ, 1'b1, 8'h00, 8'h00, 8'hFF, 1'b0}, 1'b0, 1'b0, '0);
    add_row(1'b1, 7'd0, '{MODE_READ, 1'b1, 8'h55, 8'hAA, 8'h00, 1'b0}, 1'b1, 1'b0, '0);
    // crc on, top address
    add_row(1'b1, 7'd127, '{MODE_WRITE, 1'b1, 8'h80, 8'h01, 8'h00, 1'b0}, 1'b0, 1'b0, '0);
    add_row(1'b1, 7'd127, '{MODE_WRITE, 1'b0, 8'h00, 8'hFE, 8'h00, 1'b1}, 1'b0, 1'b0, '0);
    add_row(1'b1, 7'd127, '{MODE_READ, 1'b1, 8'h7F, 8'h80, 8'h00, 1'b0}, 1'b1, 1'b0, '0);
    add_row(1'b1, 7'd127, '{MODE_READ, 1'b0, 8'h00, 8'h7F, 8'h00, 1'b1}, 1'b0, 1'b0, '0);
    add_row(1'b1, 7'd127, '{MODE_READ, 1'b0, 8'h00, 8'h11, 8'h00, 1'b0}, 1'b1, 1'b0, '0);
    add_row(1'b1, 7'd127, '{MODE_READ, 1'b0, 8'h00, 8'h22, 8'h00, 1'b1}, 1'b1, 1'b0, '0);
    // crc off again
    add_row(1'b0, 7'd127, '{MODE_READ, 1'b1, 8'hFF, 8'hFF, 8'h00, 1'b1}, 1'b0, 1'b1,
            '{8'hFF, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1});
    add_row(1'b0, 7'd127, '{MODE_WRITE, 1'b0, 8'h00, 8'h80, 8'h00, 1'b0}, 1'b0, 1'b1,
            '{8'h80, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0});
    add_row(1'b0, 7'd127, '{MODE_WRITE, 1'b0, 8'h00, 8'h01, 8'h00, 1'b1}, 1'b0, 1'b1,
            '{8'h01, 8'h00, 1'b1, 1'b0, 16'h0180, 1'b1, 1'b1});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].en != cur_en || plan[i].addr != cur_addr)
        apply_cfg(plan[i].en, plan[i].addr);
      q = plan[i].req;
      if (plan[i].fix) q.rx_crc = frame_crc(q, cur_addr);
      offer(q, plan[i].pin, 1'b0);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      en = (ph == RAND_PHASES - 1) ? 1'b0 : (ph < 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
      case (ph % 4)
        0:       addr = 7'd0;
        1:       addr = 7'd127;
        default: addr = 7'($urandom);
      endcase
      calm = ($urandom_range(0, 3) == 0);
      apply_cfg(en, addr);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          q = req_t'(27'($urandom));
          offer(q, none, calm);
          sent++;
        end else begin
          len = $urandom_range(1, 8);
          xfer_mode = 1'($urandom);
          xfer_reg = 8'($urandom);
          trunc = ($urandom_range(0, 9) == 0);
          for (int k = 0; k < len; k++) begin
            q.mode = xfer_mode;
            q.start = (k == 0);
            q.regaddr = (k == 0) ? xfer_reg : 8'($urandom);
            q.data = 8'($urandom);
            q.last = (k == len - 1) && !trunc;
            q.rx_crc = frame_crc(q, cur_addr);
            if (xfer_mode == MODE_WRITE || $urandom_range(0, 15) == 0)
              q.rx_crc = 8'($urandom);
            offer(q, none, calm);
            sent++;
          end
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_count == 0 && owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
